// File: src/best_fit_page_allocator_defines.svh
// Assertion macros used by the allocator datapath.
`ifndef BEST_FIT_PAGE_ALLOCATOR_DEFINES_SVH
`define BEST_FIT_PAGE_ALLOCATOR_DEFINES_SVH

`ifndef ASSERT_OFF
// Check prop on every clock edge outside reset.
`define BFPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check that cons follows from ante on the same edge.
`define BFPA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Check that cons follows from ante as a non-overlapping implication.
`define BFPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BFPA_ASSERT(lbl, prop, msg)
`define BFPA_ASSERT_IMP(lbl, ante, cons, msg)
`define BFPA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// File: src/bfpa_pkg.sv
package bfpa_pkg;

  localparam int NumPages   = 65536;
  localparam int MaxExtents = 64;

  localparam int PageW = $clog2(NumPages);
  localparam int CntW  = PageW + 1;
  localparam int IdxW  = $clog2(MaxExtents);
  localparam int NumW  = IdxW + 1;

  localparam logic CmdAlloc = 1'b0;
  localparam logic CmdFree  = 1'b1;

  typedef enum logic [1:0] {
    StsOk    = 2'd0,
    StsNoFit = 2'd1,
    StsZero  = 2'd2,
    StsFull  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StEval,
    StMvRd,
    StMvWr,
    StFix,
    StDone
  } state_e;

  typedef enum logic [1:0] {
    MvNone,
    MvDown,
    MvUp
  } mv_e;

  typedef struct packed {
    logic [PageW-1:0] start;
    logic [CntW-1:0]  len;
  } extent_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic eval;
    logic mv_rd;
    logic mv_wr;
    logic fix;
    logic done;
  } ctl_t;

  typedef struct packed {
    logic scan_done;
    logic mv_more;
  } stat_t;

endpackage

// File: src/bfpa_ctrl.sv
module bfpa_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  bfpa_pkg::stat_t stat_i,
  output bfpa_pkg::ctl_t  ctl_o,
  output logic           busy_o
);

  bfpa_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bfpa_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    case (state_q)
      bfpa_pkg::StIdle: begin
        if (start_i) begin
          ctl_o.load = 1'b1;
          state_d    = bfpa_pkg::StScan;
        end
      end
      bfpa_pkg::StScan: begin
        ctl_o.scan = 1'b1;
        if (stat_i.scan_done) state_d = bfpa_pkg::StEval;
      end
      bfpa_pkg::StEval: begin
        ctl_o.eval = 1'b1;
        state_d    = bfpa_pkg::StMvRd;
      end
      bfpa_pkg::StMvRd: begin
        if (stat_i.mv_more) begin
          ctl_o.mv_rd = 1'b1;
          state_d     = bfpa_pkg::StMvWr;
        end else begin
          state_d = bfpa_pkg::StFix;
        end
      end
      bfpa_pkg::StMvWr: begin
        ctl_o.mv_wr = 1'b1;
        state_d     = bfpa_pkg::StMvRd;
      end
      bfpa_pkg::StFix: begin
        ctl_o.fix = 1'b1;
        state_d   = bfpa_pkg::StDone;
      end
      bfpa_pkg::StDone: begin
        ctl_o.done = 1'b1;
        state_d    = bfpa_pkg::StIdle;
      end
      default: begin
        state_d = bfpa_pkg::StIdle;
      end
    endcase
  end

  assign busy_o = (state_q != bfpa_pkg::StIdle);

endmodule

// File: src/bfpa_dp.sv
`include "best_fit_page_allocator_defines.svh"

module bfpa_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bfpa_pkg::ctl_t              ctl_i,
  output bfpa_pkg::stat_t             stat_o,
  input  logic                        cmd_i,
  input  logic [bfpa_pkg::PageW-1:0]  start_page_i,
  input  logic [bfpa_pkg::CntW-1:0]   page_count_i,
  output logic                        done_o,
  output logic [1:0]                  status_o,
  output logic [bfpa_pkg::PageW-1:0]  alloc_start_o,
  output logic [bfpa_pkg::CntW-1:0]   free_total_o,
  output logic [bfpa_pkg::NumW-1:0]   extents_used_o
);

  localparam int PageW = bfpa_pkg::PageW;
  localparam int CntW  = bfpa_pkg::CntW;
  localparam int IdxW  = bfpa_pkg::IdxW;
  localparam int NumW  = bfpa_pkg::NumW;

  bfpa_pkg::extent_t table_mem [bfpa_pkg::MaxExtents];
  bfpa_pkg::extent_t rd_q;

  logic            cmd_q;
  logic [PageW-1:0] s_q;
  logic [CntW-1:0] n_q;
  logic [NumW-1:0] count_q;
  logic [CntW-1:0] total_q;

  logic [NumW-1:0] scan_idx_q;
  logic [IdxW-1:0] rd_idx_q;
  logic            rd_valid_q;

  logic            found_q;
  logic [IdxW-1:0] best_idx_q;
  logic [CntW-1:0] best_len_q;
  logic [PageW-1:0] best_start_q;

  logic            lo_q;
  logic [IdxW-1:0] lo_idx_q;
  logic [PageW-1:0] lo_start_q;
  logic [CntW-1:0] lo_len_q;
  logic [CntW-1:0] lo_end_q;

  logic            hi_q;
  logic [IdxW-1:0] hi_idx_q;
  logic [PageW-1:0] hi_start_q;
  logic [CntW-1:0] hi_len_q;

  bfpa_pkg::status_e sts_q, sts_d;
  logic              fix_en_q, fix_en_d;
  logic [IdxW-1:0]   fix_idx_q, fix_idx_d;
  bfpa_pkg::extent_t fix_val_q, fix_val_d;
  bfpa_pkg::mv_e     mv_q, mv_d;
  logic [NumW-1:0]   mv_ptr_q, mv_ptr_d;
  logic [NumW-1:0]   ins_q, ins_d;
  logic [NumW-1:0]   new_count_q, new_count_d;
  logic [CntW-1:0]   new_total_q, new_total_d;
  logic [PageW-1:0]  astart_q, astart_d;
  logic              done_q;

  logic [CntW-1:0] room;
  logic [CntW-1:0] n_load;
  logic            issue;
  logic            ren;
  logic [IdxW-1:0] raddr;
  logic            we;
  logic [IdxW-1:0] waddr;
  bfpa_pkg::extent_t wdata;
  logic [NumW-1:0] mv_up1;
  logic [NumW-1:0] mv_dn1;
  logic [CntW-1:0] s_ext;
  logic [CntW-1:0] sum_sc;
  logic            lo_m;
  logic            hi_m;

  // Clip a freed range to end at the top of the page space.
  assign room   = CntW'(bfpa_pkg::NumPages) - {1'b0, start_page_i};
  assign n_load = (cmd_i == bfpa_pkg::CmdFree && page_count_i > room) ? room : page_count_i;

  assign issue  = ctl_i.scan && (scan_idx_q < count_q);
  assign mv_up1 = mv_ptr_q + NumW'(1);
  assign mv_dn1 = mv_ptr_q - NumW'(1);
  assign ren    = issue || ctl_i.mv_rd;
  assign raddr  = ctl_i.mv_rd ? ((mv_q == bfpa_pkg::MvDown) ? mv_up1[IdxW-1:0]
                                                           : mv_dn1[IdxW-1:0])
                              : scan_idx_q[IdxW-1:0];
  assign we     = ctl_i.mv_wr || (ctl_i.fix && fix_en_q);
  assign waddr  = ctl_i.mv_wr ? mv_ptr_q[IdxW-1:0] : fix_idx_q;
  assign wdata  = ctl_i.mv_wr ? rd_q : fix_val_q;

  always_comb begin
    case (mv_q)
      bfpa_pkg::MvDown: stat_o.mv_more = (mv_up1 < count_q);
      bfpa_pkg::MvUp:   stat_o.mv_more = (mv_ptr_q > ins_q);
      default:          stat_o.mv_more = 1'b0;
    endcase
    stat_o.scan_done = (scan_idx_q == count_q) && !rd_valid_q;
  end

  always_ff @(posedge clk_i) begin
    if (we) table_mem[waddr] <= wdata;
    if (ren) rd_q <= table_mem[raddr];
  end

  // Work out the outcome and the table edits from the scan results.
  always_comb begin
    s_ext       = {1'b0, s_q};
    sum_sc      = s_ext + n_q;
    lo_m        = lo_q && (lo_end_q == s_ext);
    hi_m        = hi_q && (sum_sc == {1'b0, hi_start_q});
    sts_d       = bfpa_pkg::StsOk;
    fix_en_d    = 1'b0;
    fix_idx_d   = '0;
    fix_val_d   = '0;
    mv_d        = bfpa_pkg::MvNone;
    mv_ptr_d    = '0;
    ins_d       = '0;
    new_count_d = count_q;
    new_total_d = total_q;
    astart_d    = '0;
    if (cmd_q == bfpa_pkg::CmdAlloc) begin
      if (n_q == '0) begin
        sts_d = bfpa_pkg::StsZero;
      end else if (n_q > total_q || !found_q) begin
        sts_d = bfpa_pkg::StsNoFit;
      end else begin
        astart_d    = best_start_q;
        new_total_d = total_q - n_q;
        if (best_len_q > n_q) begin
          fix_en_d        = 1'b1;
          fix_idx_d       = best_idx_q;
          fix_val_d.start = best_start_q + n_q[PageW-1:0];
          fix_val_d.len   = best_len_q - n_q;
        end else begin
          mv_d        = bfpa_pkg::MvDown;
          mv_ptr_d    = NumW'(best_idx_q);
          new_count_d = count_q - NumW'(1);
        end
      end
    end else begin
      if (n_q == '0) begin
        sts_d = bfpa_pkg::StsZero;
      end else if ((lo_q && lo_end_q > s_ext) || (hi_q && sum_sc > {1'b0, hi_start_q})) begin
        sts_d = bfpa_pkg::StsNoFit;
      end else if (lo_m && hi_m) begin
        fix_en_d        = 1'b1;
        fix_idx_d       = lo_idx_q;
        fix_val_d.start = lo_start_q;
        fix_val_d.len   = lo_len_q + n_q + hi_len_q;
        mv_d            = bfpa_pkg::MvDown;
        mv_ptr_d        = NumW'(hi_idx_q);
        new_count_d     = count_q - NumW'(1);
      end else if (lo_m) begin
        fix_en_d        = 1'b1;
        fix_idx_d       = lo_idx_q;
        fix_val_d.start = lo_start_q;
        fix_val_d.len   = lo_len_q + n_q;
      end else if (hi_m) begin
        fix_en_d        = 1'b1;
        fix_idx_d       = hi_idx_q;
        fix_val_d.start = s_q;
        fix_val_d.len   = hi_len_q + n_q;
      end else if (count_q >= NumW'(bfpa_pkg::MaxExtents)) begin
        sts_d = bfpa_pkg::StsFull;
      end else begin
        ins_d           = hi_q ? NumW'(hi_idx_q) : count_q;
        fix_en_d        = 1'b1;
        fix_idx_d       = ins_d[IdxW-1:0];
        fix_val_d.start = s_q;
        fix_val_d.len   = n_q;
        mv_d            = bfpa_pkg::MvUp;
        mv_ptr_d        = count_q;
        new_count_d     = count_q + NumW'(1);
      end
      if (sts_d == bfpa_pkg::StsOk) new_total_d = total_q + n_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      total_q    <= '0;
      scan_idx_q <= '0;
      rd_valid_q <= 1'b0;
      found_q    <= 1'b0;
      lo_q       <= 1'b0;
      hi_q       <= 1'b0;
      mv_q       <= bfpa_pkg::MvNone;
      mv_ptr_q   <= '0;
      ins_q      <= '0;
      fix_en_q   <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      done_q     <= ctl_i.done;
      rd_valid_q <= issue;
      if (ctl_i.load) begin
        scan_idx_q <= '0;
        found_q    <= 1'b0;
        lo_q       <= 1'b0;
        hi_q       <= 1'b0;
      end
      if (issue) scan_idx_q <= scan_idx_q + NumW'(1);
      if (ctl_i.scan && rd_valid_q) begin
        if (rd_q.len >= n_q && (!found_q || rd_q.len < best_len_q)) found_q <= 1'b1;
        if (rd_q.start < s_q) begin
          lo_q <= 1'b1;
        end else if (!hi_q) begin
          hi_q <= 1'b1;
        end
      end
      if (ctl_i.eval) begin
        mv_q     <= mv_d;
        mv_ptr_q <= mv_ptr_d;
        ins_q    <= ins_d;
        fix_en_q <= fix_en_d;
      end
      if (ctl_i.mv_wr) begin
        mv_ptr_q <= (mv_q == bfpa_pkg::MvDown) ? mv_up1 : mv_dn1;
      end
      if (ctl_i.done) begin
        count_q <= new_count_q;
        total_q <= new_total_q;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q <= cmd_i;
      s_q   <= start_page_i;
      n_q   <= n_load;
    end
    if (issue) rd_idx_q <= scan_idx_q[IdxW-1:0];
    if (ctl_i.scan && rd_valid_q) begin
      if (rd_q.len >= n_q && (!found_q || rd_q.len < best_len_q)) begin
        best_idx_q   <= rd_idx_q;
        best_len_q   <= rd_q.len;
        best_start_q <= rd_q.start;
      end
      if (rd_q.start < s_q) begin
        lo_idx_q   <= rd_idx_q;
        lo_start_q <= rd_q.start;
        lo_len_q   <= rd_q.len;
        lo_end_q   <= {1'b0, rd_q.start} + rd_q.len;
      end else if (!hi_q) begin
        hi_idx_q   <= rd_idx_q;
        hi_start_q <= rd_q.start;
        hi_len_q   <= rd_q.len;
      end
    end
    if (ctl_i.eval) begin
      sts_q       <= sts_d;
      fix_idx_q   <= fix_idx_d;
      fix_val_q   <= fix_val_d;
      new_count_q <= new_count_d;
      new_total_q <= new_total_d;
      astart_q    <= astart_d;
    end
  end

  assign done_o         = done_q;
  assign status_o       = sts_q;
  assign alloc_start_o  = astart_q;
  assign free_total_o   = new_total_q;
  assign extents_used_o = new_count_q;

  `BFPA_ASSERT(a_count_bound, count_q <= NumW'(bfpa_pkg::MaxExtents), "extent count overflow")
  `BFPA_ASSERT_NEXT(a_done_single, done_q, !done_q, "result strobe longer than one cycle")
  `BFPA_ASSERT_IMP(a_fail_keeps_state, ctl_i.done && sts_q != bfpa_pkg::StsOk,
    new_count_q == count_q && new_total_q == total_q, "failed command changed state")
  `BFPA_ASSERT_IMP(a_fail_zero_start, done_q && sts_q != bfpa_pkg::StsOk,
    astart_q == '0, "alloc start nonzero on failure")

endmodule

// File: src/best_fit_page_allocator.sv
// Each command scans the extents held before it, evaluates the result, then shifts
// at most MaxExtents-1 table entries to insert or remove one, then writes the
// fixed-up entry and reports the result on done_o.
// Throughput: one command at a time; busy falls in the cycle the result is out.
// Cost is set by the single-port extent table: one entry read per scan cycle,
// and a read and a write per shifted entry. Results are never stalled.
// Reset clears counts and control; table contents stay undefined, no clearing pass.
module best_fit_page_allocator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic                        cmd_i,
  input  logic [bfpa_pkg::PageW-1:0]  start_page_i,
  input  logic [bfpa_pkg::CntW-1:0]   page_count_i,
  output logic                        done_o,
  output logic [1:0]                  status_o,
  output logic [bfpa_pkg::PageW-1:0]  alloc_start_o,
  output logic [bfpa_pkg::CntW-1:0]   free_total_o,
  output logic [bfpa_pkg::NumW-1:0]   extents_used_o
);

  bfpa_pkg::ctl_t  ctl;
  bfpa_pkg::stat_t stat;

  bfpa_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .ctl_o   (ctl),
    .busy_o  (busy)
  );

  bfpa_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl),
    .stat_o         (stat),
    .cmd_i          (cmd_i),
    .start_page_i   (start_page_i),
    .page_count_i   (page_count_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .alloc_start_o  (alloc_start_o),
    .free_total_o   (free_total_o),
    .extents_used_o (extents_used_o)
  );

endmodule
